>>> src/three_level_priority_tick_scheduler_assert.svh
// ----------------------------------------------------------------------------
// three_level_priority_tick_scheduler_assert.svh
// assertion macros shared by the scheduler rtl, clocked on clk, reset rst_n
// ----------------------------------------------------------------------------
`ifndef THREE_LEVEL_PRIORITY_TICK_SCHEDULER_ASSERT_SVH
`define THREE_LEVEL_PRIORITY_TICK_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define TLPTS_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TLPTS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/tlpts_pkg.sv
// ----------------------------------------------------------------------------
// tlpts_pkg
// types and constants of the three-level priority tick scheduler
// ----------------------------------------------------------------------------
package tlpts_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    typedef enum logic
    {
        CMD_TICK   = 1'b0,
        CMD_ARRIVE = 1'b1
    } cmd_t;

    typedef enum logic [2:0]
    {
        ST_IDLE       = 3'd0,
        ST_RAN        = 3'd1,
        ST_FINISHED   = 3'd2,
        ST_ACCEPTED   = 3'd3,
        ST_FULL       = 3'd4,
        ST_ZERO_BURST = 3'd5
    } status_t;

    typedef enum logic [1:0]
    {
        QSEL_NONE  = 2'd0,
        QSEL_HIGH  = 2'd1,
        QSEL_INTER = 2'd2,
        QSEL_BATCH = 2'd3
    } qsel_t;

    localparam logic [1:0] PRIO_HIGH  = 2'd1;
    localparam logic [1:0] PRIO_INTER = 2'd2;

    typedef struct packed
    {
        cmd_t        command;
        logic [7:0]  job_ident;
        logic [15:0] burst_length;
        logic [1:0]  priority_class;
    } in_t;

    typedef struct packed
    {
        status_t     status;
        logic [7:0]  result_ident;
        qsel_t       served_queue;
        logic [15:0] finish_time;
        logic [15:0] turnaround;
        logic [15:0] waiting;
        logic [15:0] response;
    } out_t;

endpackage

>>> src/three_level_priority_tick_scheduler.sv
// an arrival beat shows its result in the cycle after acceptance; a tick beat reads the job
// memory, then writes the record back in S_TICK; one arrival per cycle while not busy
// busy is high only in S_TICK, where start is ignored; results are strobed on done for one cycle
// reset clears queue pointers, counts, the time counter and the state; no memory clearing pass
// ----------------------------------------------------------------------------
// three_level_priority_tick_scheduler
// fixed-priority three-queue scheduler with job records in one synchronous memory
// ----------------------------------------------------------------------------
`include "three_level_priority_tick_scheduler_assert.svh"

module three_level_priority_tick_scheduler #(
    parameter int QUEUE_DEPTH = tlpts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  tlpts_pkg::in_t  item,
    output logic            done,
    output tlpts_pkg::out_t result
);

    localparam int SLOTS  = 3 * QUEUE_DEPTH;
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = $clog2(SLOTS);

    localparam logic [1:0] QI_HIGH  = 2'd0;
    localparam logic [1:0] QI_INTER = 2'd1;
    localparam logic [1:0] QI_BATCH = 2'd2;

    typedef enum logic [1:0]
    {
        S_IDLE = 2'b01,
        S_TICK = 2'b10
    } state_t;

    typedef struct packed
    {
        logic [7:0]  ident;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [15:0] remaining;
        logic [15:0] first_start;
        logic        started;
    } slot_t;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [1:0] q,
                                                    input logic [PTR_W-1:0] ptr);
        logic [ADDR_W-1:0] base;
        case (q)
            QI_HIGH:  base = '0;
            QI_INTER: base = ADDR_W'(QUEUE_DEPTH);
            default:  base = ADDR_W'(2 * QUEUE_DEPTH);
        endcase
        return base + ADDR_W'(ptr);
    endfunction

    function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    slot_t             slot_mem [SLOTS];
    slot_t             rd_reg;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    slot_t             mem_wdata;

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  head_reg [3];
    logic [PTR_W-1:0]  head_next [3];
    logic [PTR_W-1:0]  tail_reg [3];
    logic [PTR_W-1:0]  tail_next [3];
    logic [CNT_W-1:0]  count_reg [3];
    logic [CNT_W-1:0]  count_next [3];
    logic [15:0]       now_reg, now_next;
    logic [1:0]        tq_reg, tq_next;
    logic              tfound_reg, tfound_next;
    logic [ADDR_W-1:0] taddr_reg, taddr_next;
    logic              done_reg, done_next;
    tlpts_pkg::out_t   result_reg, result_next;

    logic              in_acc;
    logic [1:0]        arr_q;
    logic [1:0]        find_q;
    logic              find_ok;
    logic [15:0]       rem_new;
    logic [15:0]       start_new;
    logic [15:0]       fin_time;
    logic [15:0]       tat_time;

    assign busy   = (state_reg == S_TICK);
    assign done   = done_reg;
    assign result = result_reg;
    assign in_acc = start && !busy;

    assign arr_q = (item.priority_class == tlpts_pkg::PRIO_HIGH)  ? QI_HIGH  :
                   (item.priority_class == tlpts_pkg::PRIO_INTER) ? QI_INTER : QI_BATCH;

    assign find_ok = (count_reg[QI_HIGH] != '0) || (count_reg[QI_INTER] != '0)
                     || (count_reg[QI_BATCH] != '0);
    assign find_q  = (count_reg[QI_HIGH] != '0)  ? QI_HIGH  :
                     (count_reg[QI_INTER] != '0) ? QI_INTER : QI_BATCH;

    // tick arithmetic on the head record read last cycle
    assign rem_new   = rd_reg.remaining - 16'd1;
    assign start_new = rd_reg.started ? rd_reg.first_start : now_reg;
    assign fin_time  = now_reg + 16'd1;
    assign tat_time  = fin_time - rd_reg.arrival;

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        now_next    = now_reg;
        tq_next     = tq_reg;
        tfound_next = tfound_reg;
        taddr_next  = taddr_reg;
        done_next   = 1'b0;
        result_next = '0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = '0;
        mem_raddr   = '0;
        mem_wdata   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (item.command == tlpts_pkg::CMD_ARRIVE)
                    begin
                        done_next                = 1'b1;
                        result_next.result_ident = item.job_ident;
                        result_next.served_queue = tlpts_pkg::qsel_t'(arr_q + 2'd1);
                        if (item.burst_length == 16'd0)
                        begin
                            result_next.status = tlpts_pkg::ST_ZERO_BURST;
                        end
                        else if (count_reg[arr_q] == CNT_W'(QUEUE_DEPTH))
                        begin
                            result_next.status = tlpts_pkg::ST_FULL;
                        end
                        else
                        begin
                            result_next.status    = tlpts_pkg::ST_ACCEPTED;
                            mem_we                = 1'b1;
                            mem_waddr             = slot_addr(arr_q, tail_reg[arr_q]);
                            mem_wdata.ident       = item.job_ident;
                            mem_wdata.arrival     = now_reg;
                            mem_wdata.burst       = item.burst_length;
                            mem_wdata.remaining   = item.burst_length;
                            mem_wdata.first_start = 16'd0;
                            mem_wdata.started     = 1'b0;
                            tail_next[arr_q]      = next_pos(tail_reg[arr_q]);
                            count_next[arr_q]     = count_reg[arr_q] + 1'b1;
                        end
                    end
                    else
                    begin
                        mem_re      = 1'b1;
                        mem_raddr   = slot_addr(find_q, head_reg[find_q]);
                        taddr_next  = mem_raddr;
                        tq_next     = find_q;
                        tfound_next = find_ok;
                        state_next  = S_TICK;
                    end
                end
            end
            S_TICK:
            begin
                done_next  = 1'b1;
                now_next   = now_reg + 16'd1;
                state_next = S_IDLE;
                if (tfound_reg)
                begin
                    mem_we                   = 1'b1;
                    mem_waddr                = taddr_reg;
                    mem_wdata                = rd_reg;
                    mem_wdata.remaining      = rem_new;
                    mem_wdata.first_start    = start_new;
                    mem_wdata.started        = 1'b1;
                    result_next.result_ident = rd_reg.ident;
                    result_next.served_queue = tlpts_pkg::qsel_t'(tq_reg + 2'd1);
                    if (rem_new == 16'd0)
                    begin
                        result_next.status      = tlpts_pkg::ST_FINISHED;
                        result_next.finish_time = fin_time;
                        result_next.turnaround  = tat_time;
                        result_next.waiting     = tat_time - rd_reg.burst;
                        result_next.response    = start_new - rd_reg.arrival;
                        head_next[tq_reg]       = next_pos(head_reg[tq_reg]);
                        count_next[tq_reg]      = count_reg[tq_reg] - 1'b1;
                    end
                    else
                    begin
                        result_next.status = tlpts_pkg::ST_RAN;
                    end
                end
                else
                begin
                    result_next.status = tlpts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '{default: '0};
            tail_reg   <= '{default: '0};
            count_reg  <= '{default: '0};
            now_reg    <= '0;
            tfound_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            now_reg    <= now_next;
            tfound_reg <= tfound_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tq_reg     <= tq_next;
        taddr_reg  <= taddr_next;
        result_reg <= result_next;
    end

    // job record memory, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_reg <= slot_mem[mem_raddr];
        end
    end

    `TLPTS_ASSERT_IMPL(a_done_when_free, done, !busy, "result strobed while busy")
    `TLPTS_ASSERT_NEXT(a_tick_completes, state_reg == S_TICK, done && !busy,
                       "tick did not complete in its second cycle")
    `TLPTS_ASSERT_NEXT(a_arrive_one_cycle, in_acc && item.command == tlpts_pkg::CMD_ARRIVE,
                       done && !busy, "arrival result missing")
    `TLPTS_ASSERT_IMPL(a_count_bound, 1'b1,
                       count_reg[QI_HIGH] <= CNT_W'(QUEUE_DEPTH)
                       && count_reg[QI_INTER] <= CNT_W'(QUEUE_DEPTH)
                       && count_reg[QI_BATCH] <= CNT_W'(QUEUE_DEPTH),
                       "queue count overflow")
    `TLPTS_ASSERT_IMPL(a_finish_served, done && result.status == tlpts_pkg::ST_FINISHED,
                       result.served_queue != tlpts_pkg::QSEL_NONE, "finish without queue")

endmodule
